// ===== rtl/core/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg: shared definitions of the Huffman code builder
// Sizes of the node and leaf stores and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package hcb_pkg;
	localparam int MaxSymbols = 64;
	localparam int FreqBits   = 20;
	localparam int NodeDepth  = 2 * MaxSymbols - 1;
	localparam int NodeBits   = $clog2(NodeDepth);
	localparam int LeafBits   = $clog2(MaxSymbols);
	localparam int CountBits  = $clog2(MaxSymbols + 1);
	localparam int WeightBits = FreqBits + LeafBits;
	localparam int CodeBits   = 63;
	localparam int LenBits    = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_MERGE1,
		ST_MERGE2,
		ST_E_START,
		ST_E_CHK,
		ST_E_USE
	} hcb_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/huffman_code_builder_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_unit: Huffman code table builder
// Loads symbol and frequency entries, merges the two lightest live nodes until
// one tree remains, then emits one code per loaded entry in load order.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// s_*      in         tdata: symbol[7:0], frequency[27:8]; tlast: last
// m_*      out        tdata: out_symbol, code_bits, code_length; tuser: overflow;
//                     tlast: final_res
// Loading accepts an item on each handshake. Each merge runs one pass of the
// shared two-minimum compare unit over all nodes created so far, then the
// write states ST_MERGE1 and ST_MERGE2. Each code walks from its leaf toward
// the root, one code bit per ST_E_CHK and ST_E_USE pair, and waits on
// m_tready. arst_n clears the sequencer, item count and live bits; no
// clearing pass is needed. s_tready is low from the last item to the last code.
`default_nettype none
module huffman_code_builder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // symbol[7:0], frequency[27:8], zeros
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // out_symbol[7:0], code_bits[70:8],
	                                   // code_length[76:71], zeros
	output logic             m_tuser,  // overflow
	output logic             m_tlast
);
	localparam int NB = hcb_pkg::NodeBits;
	localparam int WB = hcb_pkg::WeightBits;

	hcb_pkg::hcb_state_t state_q, state_nx;

	logic [WB-1:0]  wmem [hcb_pkg::NodeDepth];
	logic [NB:0]    pbmem [hcb_pkg::NodeDepth];
	logic [7:0]     smem [hcb_pkg::MaxSymbols];
	logic [hcb_pkg::NodeDepth-1:0] alive_q;

	logic [hcb_pkg::CountBits-1:0] cnt_q;
	logic           drop_q;
	logic [NB-1:0]  total_q, root_q, idx_q, idx_s1, cur_q;
	logic [NB-1:0]  m1i_q, m2i_q;
	logic [WB-1:0]  m1w_q, m2w_q, w_s1;
	logic           have1_q, have2_q, al_s1, vld_s1;
	logic [hcb_pkg::LeafBits-1:0] k_q;
	logic [NB:0]    pb_rd;
	logic [7:0]     sym_rd;
	logic [hcb_pkg::CodeBits-1:0] code_q;
	logic [hcb_pkg::LenBits-1:0]  len_q;
	logic           ov_q, valid_q, fin_q;
	logic [7:0]     osym_q;
	logic [hcb_pkg::CodeBits-1:0] ocode_q;
	logic [hcb_pkg::LenBits-1:0]  olen_q;

	logic           s_acc, done_walk, last_code;
	logic [hcb_pkg::CountBits-1:0] n_new;
	logic           pb_we;
	logic [NB-1:0]  pb_wa;
	logic [NB:0]    pb_wd;

	assign s_acc     = s_tvalid && s_tready;
	assign n_new     = (cnt_q < hcb_pkg::CountBits'(hcb_pkg::MaxSymbols)) ?
	                   cnt_q + 1'b1 : cnt_q;
	assign done_walk = (cur_q == root_q) || (len_q == '1);
	assign last_code = ({1'b0, k_q} == cnt_q - 1'b1);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			hcb_pkg::ST_LOAD: begin
				if (s_acc && s_tlast) begin
					state_nx = (n_new == 1) ? hcb_pkg::ST_E_START : hcb_pkg::ST_SCAN;
				end
			end
			hcb_pkg::ST_SCAN: begin
				if (idx_q == total_q - 1'b1) state_nx = hcb_pkg::ST_DRAIN;
			end
			hcb_pkg::ST_DRAIN:  state_nx = hcb_pkg::ST_MERGE1;
			hcb_pkg::ST_MERGE1: state_nx = hcb_pkg::ST_MERGE2;
			hcb_pkg::ST_MERGE2: begin
				state_nx = (total_q == root_q) ? hcb_pkg::ST_E_START : hcb_pkg::ST_SCAN;
			end
			hcb_pkg::ST_E_START: state_nx = hcb_pkg::ST_E_CHK;
			hcb_pkg::ST_E_CHK: begin
				if (valid_q) begin
					if (m_tready) begin
						state_nx = last_code ? hcb_pkg::ST_LOAD : hcb_pkg::ST_E_START;
					end
				end else if (!done_walk) begin
					state_nx = hcb_pkg::ST_E_USE;
				end
			end
			hcb_pkg::ST_E_USE:  state_nx = hcb_pkg::ST_E_CHK;
			default:            state_nx = hcb_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = (state_q == hcb_pkg::ST_LOAD);
		m_tvalid = valid_q;
		m_tdata  = {3'b000, olen_q, ocode_q, osym_q};
		m_tuser  = ov_q;
		m_tlast  = fin_q;
		pb_we    = (state_q == hcb_pkg::ST_MERGE1) || (state_q == hcb_pkg::ST_MERGE2);
		pb_wa    = (state_q == hcb_pkg::ST_MERGE1) ? m1i_q : m2i_q;
		pb_wd    = {(state_q == hcb_pkg::ST_MERGE2), total_q};
	end

	always_ff @(posedge clk) begin
		if (s_acc && cnt_q < hcb_pkg::CountBits'(hcb_pkg::MaxSymbols)) begin
			smem[cnt_q[hcb_pkg::LeafBits-1:0]] <= s_tdata[7:0];
			wmem[NB'(cnt_q)] <= WB'(s_tdata[8 +: hcb_pkg::FreqBits]);
		end else if (state_q == hcb_pkg::ST_MERGE1) begin
			wmem[total_q] <= m1w_q + m2w_q;
		end
		if (pb_we) pbmem[pb_wa] <= pb_wd;
		w_s1   <= wmem[idx_q];
		pb_rd  <= pbmem[cur_q];
		sym_rd <= smem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcb_pkg::ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			alive_q <= '0;
			valid_q <= 1'b0;
			vld_s1  <= 1'b0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == hcb_pkg::ST_SCAN);
			idx_s1  <= idx_q;
			al_s1   <= alive_q[idx_q];
			if (state_q == hcb_pkg::ST_SCAN) idx_q <= idx_q + 1'b1;
			if (state_nx == hcb_pkg::ST_SCAN && state_q != hcb_pkg::ST_SCAN) begin
				idx_q   <= '0;
				have1_q <= 1'b0;
				have2_q <= 1'b0;
			end
			if (vld_s1 && al_s1) begin
				if (!have1_q || w_s1 < m1w_q) begin
					m2w_q <= m1w_q; m2i_q <= m1i_q; have2_q <= have1_q;
					m1w_q <= w_s1;  m1i_q <= idx_s1; have1_q <= 1'b1;
				end else if (!have2_q || w_s1 < m2w_q) begin
					m2w_q <= w_s1; m2i_q <= idx_s1; have2_q <= 1'b1;
				end
			end
			if (s_acc) begin
				if (cnt_q < hcb_pkg::CountBits'(hcb_pkg::MaxSymbols)) begin
					alive_q[NB'(cnt_q)] <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
				if (s_tlast) begin
					total_q <= NB'(n_new);
					root_q  <= NB'({n_new, 1'b0} - 2'd2);
					k_q     <= '0;
				end
			end
			if (state_q == hcb_pkg::ST_MERGE1) begin
				alive_q[m1i_q]   <= 1'b0;
				alive_q[m2i_q]   <= 1'b0;
				alive_q[total_q] <= 1'b1;
			end
			if (state_q == hcb_pkg::ST_MERGE2) total_q <= total_q + 1'b1;
			if (state_q == hcb_pkg::ST_E_START) begin
				cur_q  <= NB'(k_q);
				len_q  <= '0;
				code_q <= '0;
			end
			if (state_q == hcb_pkg::ST_E_USE) begin
				code_q <= code_q | (hcb_pkg::CodeBits'(pb_rd[NB]) << len_q);
				len_q  <= len_q + 1'b1;
				cur_q  <= pb_rd[NB-1:0];
			end
			if (state_q == hcb_pkg::ST_E_CHK) begin
				if (valid_q) begin
					if (m_tready) begin
						valid_q <= 1'b0;
						if (last_code) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							alive_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end else if (done_walk) begin
					valid_q <= 1'b1;
					osym_q  <= sym_rd;
					ocode_q <= code_q;
					olen_q  <= len_q;
					ov_q    <= drop_q;
					fin_q   <= last_code;
				end
			end
		end
	end
endmodule
`default_nettype wire
